>>> hw/rtl/ultrasonic_ranger_with_pwm_map_top_defines.svh
// assertion macros for the ultrasonic ranger block
`ifndef ULTRASONIC_RANGER_WITH_PWM_MAP_TOP_DEFINES_SVH
`define ULTRASONIC_RANGER_WITH_PWM_MAP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock outside reset
`define URPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define URPM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define URPM_ASSERT(lbl, prop, msg)
`define URPM_NEVER(lbl, cond, msg)
`endif

`endif

>>> hw/rtl/urpm_pkg.sv
// shared types and constants of the ultrasonic ranger block
package urpm_pkg;

  // tick counter and echo width
  localparam int CNT_W   = 17;
  localparam int WIDTH_W = 16;

  // fixed trigger sequence, in ticks
  localparam logic [CNT_W-1:0] TRIG_LOW_TICKS  = CNT_W'(4);
  localparam logic [CNT_W-1:0] TRIG_HIGH_TICKS = CNT_W'(20);

  // register reset values
  localparam logic [CNT_W-1:0]   WAIT_LIMIT_RST = CNT_W'(72000);
  localparam logic [WIDTH_W-1:0] WIDTH_CAP_RST  = WIDTH_W'(46400);
  localparam logic [WIDTH_W-1:0] HOLDOFF_RST    = WIDTH_W'(20000);

  // width to distance: cm = width * 2248 >> 18
  localparam int SCALE_W    = 12;
  localparam int PROD_W     = WIDTH_W + SCALE_W;
  localparam int DIST_SHIFT = 18;
  localparam int DIST_W     = 9;
  localparam logic [SCALE_W-1:0] DIST_SCALE = SCALE_W'(2248);
  localparam logic [DIST_W-1:0]  DIST_MAX   = '1;

  // distance to duty map
  localparam int DUTY_W = 8;
  localparam int K_W    = 6;
  localparam int NUM_W  = 13;
  localparam int REM_W  = 6;
  localparam logic [DIST_W-1:0] NEAR_CM    = DIST_W'(12);
  localparam logic [DIST_W-1:0] FAR_CM     = DIST_W'(46);
  localparam logic [DUTY_W-1:0] DUTY_NEAR  = DUTY_W'(255);
  localparam logic [DUTY_W-1:0] DUTY_FAR   = DUTY_W'(26);
  localparam logic [NUM_W-1:0]  MAP_MUL    = NUM_W'(229);
  localparam logic [NUM_W-1:0]  MAP_ROUND  = NUM_W'(33);
  localparam logic [REM_W:0]    MAP_DEN    = (REM_W + 1)'(34);

  // serial step counts
  localparam int MUL_STEPS  = WIDTH_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_CNT_W = $clog2(MUL_STEPS);
  localparam logic [STEP_CNT_W-1:0] MUL_LAST = STEP_CNT_W'(MUL_STEPS - 1);
  localparam logic [STEP_CNT_W-1:0] DIV_LAST = STEP_CNT_W'(DIV_STEPS - 1);

  localparam int IDX_W = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_WAIT_LIMIT = 2'd0,
    REG_WIDTH_CAP  = 2'd1,
    REG_HOLDOFF    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TLOW  = 3'd1,
    PH_THIGH = 3'd2,
    PH_WAIT  = 3'd3,
    PH_MEAS  = 3'd4,
    PH_HOLD  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    DS_IDLE = 3'd0,
    DS_MUL  = 3'd1,
    DS_MAP  = 3'd2,
    DS_DIV  = 3'd3,
    DS_FIN  = 3'd4
  } dist_state_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_word_t;

  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;
    logic [DUTY_W-1:0] duty;
  } result_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]   wait_limit;
    logic [WIDTH_W-1:0] width_cap;
    logic [WIDTH_W-1:0] holdoff;
  } cfg_regs_t;

  typedef struct packed {
    logic               go;
    logic [WIDTH_W-1:0] width;
  } calc_req_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } dist_stat_t;

  typedef struct packed {
    logic trigger;
    logic busy;
    logic done;
    logic timed_out;
  } tick_flags_t;

endpackage

>>> hw/rtl/urpm_chan_if.sv
// valid/ready channel carrying one word of any packed type
interface urpm_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/urpm_seq.sv
// measurement sequencer: trigger, echo wait, echo width and hold-off phases
module urpm_seq import urpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  tick_word_t  word,
  input  cfg_regs_t   regs,
  output tick_flags_t flags,
  output calc_req_t   req
);

  phase_t           phase;
  phase_t           phase_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_inc;
  logic             done;
  logic             done_next;
  logic             tmo;
  logic             tmo_next;

  assign count_inc = count + 1'b1;

  always_comb begin
    phase_next = phase;
    count_next = count_inc;
    done_next  = 1'b0;
    tmo_next   = 1'b0;
    req.go     = 1'b0;
    // captured width, capped
    req.width  = (count > {1'b0, regs.width_cap}) ? regs.width_cap : count[WIDTH_W-1:0];
    unique case (phase)
      PH_TLOW: begin
        if (count >= TRIG_LOW_TICKS) begin
          phase_next = PH_THIGH;
          count_next = CNT_W'(1);
        end
      end
      PH_THIGH: begin
        if (count >= TRIG_HIGH_TICKS) begin
          phase_next = PH_WAIT;
          count_next = '0;
        end
      end
      PH_WAIT: begin
        priority if (word.echo) begin
          phase_next = PH_MEAS;
          count_next = CNT_W'(1);
        end else if (count >= regs.wait_limit) begin
          tmo_next   = 1'b1;
          phase_next = PH_IDLE;
          count_next = '0;
        end
      end
      PH_MEAS: begin
        if (!word.echo || count >= {1'b0, regs.width_cap}) begin
          done_next  = 1'b1;
          req.go     = step;
          count_next = '0;
          phase_next = (regs.holdoff == '0) ? PH_IDLE : PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (count_inc >= {1'b0, regs.holdoff}) begin
          phase_next = PH_IDLE;
          count_next = '0;
        end
      end
      default: begin
        phase_next = word.start_req ? PH_TLOW : PH_IDLE;
        count_next = word.start_req ? CNT_W'(1) : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
      done  <= 1'b0;
      tmo   <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
      done  <= done_next;
      tmo   <= tmo_next;
    end
  end

  assign flags.trigger   = (phase == PH_THIGH);
  assign flags.busy      = (phase != PH_IDLE);
  assign flags.done      = done;
  assign flags.timed_out = tmo;

endmodule

>>> hw/rtl/urpm_dist.sv
// bit-serial width to distance multiply and serial duty map division
module urpm_dist import urpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  calc_req_t         req,
  output dist_stat_t        stat,
  output logic [DIST_W-1:0] distance_cm,
  output logic [DUTY_W-1:0] duty
);

  dist_state_t            state;
  dist_state_t            state_next;
  logic [STEP_CNT_W-1:0]  cnt;
  logic [STEP_CNT_W-1:0]  cnt_next;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      prod_next;
  logic [NUM_W-1:0]       num;
  logic [NUM_W-1:0]       num_next;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_next;
  logic [DIST_W-1:0]      dist_next;
  logic [DUTY_W-1:0]      duty_next;

  logic [SCALE_W:0]       mul_sum;
  logic [DIST_W-1:0]      d_sat;
  logic [DIST_W-1:0]      k_full;
  logic [NUM_W-1:0]       map_num;
  logic [REM_W:0]         div_try;
  logic [REM_W:0]         div_sub;
  logic                   div_ge;
  logic [REM_W-1:0]       div_rem;
  logic [NUM_W-1:0]       div_quo;

  // shift-add: multiplier bits leave the low end, product grows from the top
  assign mul_sum = {1'b0, prod[PROD_W-1:WIDTH_W]} + (prod[0] ? {1'b0, DIST_SCALE} : '0);

  // product >> 18 with saturation at the 9-bit limit
  assign d_sat   = prod[PROD_W-1] ? DIST_MAX : prod[PROD_W-2:DIST_SHIFT];
  assign k_full  = d_sat - NEAR_CM;
  assign map_num = NUM_W'(k_full[K_W-1:0]) * MAP_MUL + MAP_ROUND;

  // restoring division by the map denominator, one quotient bit a cycle
  assign div_try = {rem, num[NUM_W-1]};
  assign div_ge  = (div_try >= MAP_DEN);
  assign div_sub = div_try - MAP_DEN;
  assign div_rem = div_ge ? div_sub[REM_W-1:0] : div_try[REM_W-1:0];
  assign div_quo = {num[NUM_W-2:0], div_ge};

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    prod_next  = prod;
    num_next   = num;
    rem_next   = rem;
    dist_next  = distance_cm;
    duty_next  = duty;
    unique case (state)
      DS_IDLE: begin
        if (req.go) begin
          prod_next  = {SCALE_W'(0), req.width};
          cnt_next   = '0;
          state_next = DS_MUL;
        end
      end
      DS_MUL: begin
        prod_next = {mul_sum, prod[WIDTH_W-1:1]};
        cnt_next  = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = DS_MAP;
        end
      end
      DS_MAP: begin
        dist_next = d_sat;
        cnt_next  = '0;
        rem_next  = '0;
        num_next  = map_num;
        priority if (d_sat >= FAR_CM) begin
          duty_next  = DUTY_FAR;
          state_next = DS_FIN;
        end else if (d_sat <= NEAR_CM) begin
          duty_next  = DUTY_NEAR;
          state_next = DS_FIN;
        end else begin
          state_next = DS_DIV;
        end
      end
      DS_DIV: begin
        num_next = div_quo;
        rem_next = div_rem;
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          duty_next  = DUTY_NEAR - div_quo[DUTY_W-1:0];
          state_next = DS_FIN;
        end
      end
      DS_FIN: begin
        state_next = DS_IDLE;
      end
      default: begin
        state_next = DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    prod <= prod_next;
    num  <= num_next;
    rem  <= rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_cm <= '0;
      duty        <= DUTY_FAR;
    end else begin
      distance_cm <= dist_next;
      duty        <= duty_next;
    end
  end

  assign stat.busy = (state != DS_IDLE);
  assign stat.fin  = (state == DS_FIN);

endmodule

>>> hw/rtl/ultrasonic_ranger_with_pwm_map_top.sv
// ultrasonic echo ranger with distance to pwm duty map, top level
//
// tick channel: one word per 0.5 us sensor tick (start_req, echo level)
// result channel: one word per tick word (trigger, busy, done, timeout,
//   last distance in cm, pwm duty), in tick order
// cfg channel: register writes (echo wait limit, echo width cap, hold-off),
//   always ready, meant to be written while the block is idle
// result path: an ordinary tick passes the emit flag and then the output register
//   before it shows at the result port; tick ready stays low while its result is emitted
// a tick that ends a measurement runs the bit-serial multiply, then the map state
//   and, for 13..45 cm, the serial division, then the finish state; the division
//   is skipped when the duty saturates
// reset: idle phase, distance 0, duty 26, registers at their defaults
// stall: one finished word waits in the output register while the next tick
//   word is taken; its result parks in a skid register, and tick ready drops
//   until the skid register drains
`include "ultrasonic_ranger_with_pwm_map_top_defines.svh"

module ultrasonic_ranger_with_pwm_map_top import urpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  urpm_chan_if.sink   tick,
  urpm_chan_if.source result,
  urpm_chan_if.sink   cfg
);

  cfg_regs_t         regs;
  calc_req_t         req;
  dist_stat_t        dstat;
  tick_flags_t       flags;
  logic [DIST_W-1:0] distance_cm;
  logic [DUTY_W-1:0] duty;

  logic              tick_acc;
  logic              emit;
  logic              res_valid;
  result_word_t      res_word;
  logic              out_valid;
  logic              out_free;
  result_word_t      out_word;
  logic              skid_valid;
  result_word_t      skid_word;

  // config registers, writes land at once
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wait_limit <= WAIT_LIMIT_RST;
      regs.width_cap  <= WIDTH_CAP_RST;
      regs.holdoff    <= HOLDOFF_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.data.index))
        REG_WAIT_LIMIT: regs.wait_limit <= cfg.data.value;
        REG_WIDTH_CAP:  regs.width_cap  <= cfg.data.value[WIDTH_W-1:0];
        REG_HOLDOFF:    regs.holdoff    <= cfg.data.value[WIDTH_W-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // one tick in flight: hold off while the distance unit runs, while a
  // result is about to be emitted, or while the skid register is full
  assign tick.ready = !dstat.busy && !emit && !skid_valid;
  assign tick_acc   = tick.valid && tick.ready;

  urpm_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .step  (tick_acc),
    .word  (tick.data),
    .regs  (regs),
    .flags (flags),
    .req   (req)
  );

  urpm_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .stat        (dstat),
    .distance_cm (distance_cm),
    .duty        (duty)
  );

  // ordinary ticks emit the cycle after acceptance, finishing ticks when
  // the distance unit is through
  always_ff @(posedge clk) begin
    if (rst) begin
      emit <= 1'b0;
    end else begin
      emit <= tick_acc && !req.go;
    end
  end

  assign res_valid            = emit || dstat.fin;
  assign res_word.trigger     = flags.trigger;
  assign res_word.busy_res    = flags.busy;
  assign res_word.done_res    = flags.done;
  assign res_word.timed_out   = flags.timed_out;
  assign res_word.distance_cm = distance_cm;
  assign res_word.duty        = duty;

  // output register with one skid entry behind it
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= skid_valid && res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (res_valid) begin
        out_word <= res_word;
      end
    end
    if (res_valid && (!out_free || skid_valid)) begin
      skid_word <= res_word;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_word;

  // a new result never arrives while the skid entry is still occupied
  `URPM_NEVER(a_skid_no_overrun, skid_valid && res_valid, "skid register overrun")
  // after a finished distance calculation the output register is valid next cycle, holding the result or an older word
  `URPM_ASSERT(a_fin_lands, dstat.fin |=> out_valid, "distance result not presented")
  // a tick either completes a measurement or times out, never both
  `URPM_NEVER(a_done_tmo_excl, res_valid && res_word.done_res && res_word.timed_out,
    "done and timeout in one word")

endmodule
